>>> rtl/esd_pkg.sv
// shared types for the escape sequence decoder
package esd_pkg;

  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned ERROR_COLUMN_BITS = 16;

  // one decoded input item as handed from front to back
  typedef struct packed {
    logic [1:0]                         count;
    logic [MAX_RESULTS-1:0][7:0]        bytes;
    logic                               is_error;
    logic [ERROR_COLUMN_BITS-1:0]       error_column;
    logic                               done;
  } job_t;

endpackage

>>> rtl/escape_sequence_decoder.sv
// top level of the string escape decoder with utf-8 encoding
//
//  channel  signals                                          direction
//  input    in_valid in_stall in_byte start_column           in (stall out)
//           first_byte end_of_text
//  output   out_valid out_stall out_byte is_error            out (stall in)
//           error_column literal_done run_last
//
// one input byte per cycle when each byte gives at most one result and out_stall is low
// a \u escape gives up to three results, one per cycle from the output register while out_stall is low
// a four-entry job queue decouples the decode front from the output back
// in_stall rises only when the queue is full; reset clears queue and decoder
module escape_sequence_decoder #(
  parameter int unsigned COLUMN_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic [15:0] start_column,
  input  logic        first_byte,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        is_error,
  output logic [15:0] error_column,
  output logic        literal_done,
  output logic        run_last
);

  logic          fire;
  logic          job_valid;
  esd_pkg::job_t job;
  logic          q_ready;
  logic          q_valid;
  logic          q_pop;
  esd_pkg::job_t q_job;

  assign in_stall = !q_ready;
  assign fire     = in_valid && !in_stall;

  esd_front #(
    .COLUMN_WIDTH(COLUMN_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .in_byte      (in_byte),
    .start_column (start_column),
    .first_byte   (first_byte),
    .end_of_text  (end_of_text),
    .job_valid    (job_valid),
    .job          (job)
  );

  esd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (fire && job_valid),
    .push_job   (job),
    .ready      (q_ready),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (q_job)
  );

  esd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_job        (q_job),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .is_error     (is_error),
    .error_column (error_column),
    .literal_done (literal_done),
    .run_last     (run_last)
  );

endmodule

>>> rtl/esd_front.sv
// front stage: escape scanning, column tracking and utf-8 encoding per item
module esd_front #(
  parameter int unsigned COLUMN_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          in_byte,
  input  logic [15:0]         start_column,
  input  logic                first_byte,
  input  logic                end_of_text,
  output logic                job_valid,
  output esd_pkg::job_t       job
);

  localparam int unsigned SW = (COLUMN_WIDTH > 16) ? COLUMN_WIDTH : 16;
  localparam int unsigned EW = (COLUMN_WIDTH > esd_pkg::ERROR_COLUMN_BITS) ?
                               COLUMN_WIDTH : esd_pkg::ERROR_COLUMN_BITS;

  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_LOWER_X   = 8'h78;
  localparam logic [7:0] CHAR_LOWER_U   = 8'h75;

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_HEX  = 2'd2
  } mode_t;

  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] r;
    begin
      case (c)
        8'h6E:   r = {1'b1, 8'h0A};
        8'h72:   r = {1'b1, 8'h0D};
        8'h74:   r = {1'b1, 8'h09};
        8'h76:   r = {1'b1, 8'h0B};
        8'h62:   r = {1'b1, 8'h08};
        8'h30:   r = {1'b1, 8'h00};
        8'h5C:   r = {1'b1, c};
        8'h22:   r = {1'b1, c};
        8'h27:   r = {1'b1, c};
        8'h24:   r = {1'b1, c};
        default: r = {1'b0, 8'h00};
      endcase
      return r;
    end
  endfunction

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    begin
      if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
      else r = 5'd0;
      return r;
    end
  endfunction

  mode_t                   scan_mode, mode_cur, scan_mode_next;
  logic [15:0]             hex_value, hex_cur, hex_value_next, hex_acc;
  logic [2:0]              digits_left, digits_cur, digits_left_next;
  logic                    wide_escape, wide_cur, wide_escape_next;
  logic [COLUMN_WIDTH-1:0] codepoint_count, count_cur, codepoint_count_next, count_adv;
  logic [1:0]              utf8_skip, skip_cur, utf8_skip_next, skip_adv;
  logic [COLUMN_WIDTH-1:0] escape_column, esc_cur, escape_column_next;
  logic [COLUMN_WIDTH-1:0] base_column, base_column_next;
  logic                    drop_rest, drop_cur, drop_rest_next;

  logic [SW-1:0]           start_ext;
  logic [COLUMN_WIDTH-1:0] start_sat;
  logic [COLUMN_WIDTH:0]   col_sum;
  logic [COLUMN_WIDTH-1:0] column;
  logic [COLUMN_WIDTH-1:0] err_col;
  logic [EW-1:0]           err_wide;
  logic [4:0]              digit;
  logic [8:0]              simple;
  logic [1:0]              n;
  logic [7:0]              b0, b1, b2;
  logic                    err;

  always_comb begin
    start_ext = SW'(start_column);
    if (start_ext > SW'({COLUMN_WIDTH{1'b1}})) start_sat = '1;
    else start_sat = start_ext[COLUMN_WIDTH-1:0];

    mode_cur   = first_byte ? MODE_TEXT : scan_mode;
    hex_cur    = first_byte ? 16'd0 : hex_value;
    digits_cur = first_byte ? 3'd0 : digits_left;
    wide_cur   = first_byte ? 1'b0 : wide_escape;
    count_cur  = first_byte ? '0 : codepoint_count;
    skip_cur   = first_byte ? 2'd0 : utf8_skip;
    esc_cur    = first_byte ? '0 : escape_column;
    drop_cur   = first_byte ? 1'b0 : drop_rest;
    base_column_next = first_byte ? start_sat : base_column;

    col_sum = {1'b0, base_column_next} + {1'b0, count_cur};
    column  = col_sum[COLUMN_WIDTH] ? '1 : col_sum[COLUMN_WIDTH-1:0];

    count_adv = count_cur;
    skip_adv  = skip_cur;
    if (skip_cur != 2'd0) begin
      skip_adv = skip_cur - 2'd1;
    end else begin
      if (count_cur != '1) count_adv = count_cur + COLUMN_WIDTH'(1);
      if ((in_byte & 8'hE0) == 8'hC0) skip_adv = 2'd1;
      else if ((in_byte & 8'hF0) == 8'hE0) skip_adv = 2'd2;
      else if ((in_byte & 8'hF8) == 8'hF0) skip_adv = 2'd3;
    end

    digit   = hex_digit(in_byte);
    simple  = simple_escape(in_byte);
    hex_acc = {hex_cur[11:0], digit[3:0]};

    scan_mode_next       = mode_cur;
    hex_value_next       = hex_cur;
    digits_left_next     = digits_cur;
    wide_escape_next     = wide_cur;
    codepoint_count_next = count_adv;
    utf8_skip_next       = skip_adv;
    escape_column_next   = esc_cur;
    drop_rest_next       = drop_cur;
    err_col = esc_cur;
    n   = 2'd0;
    b0  = 8'd0;
    b1  = 8'd0;
    b2  = 8'd0;
    err = 1'b0;

    if (drop_cur) begin
      codepoint_count_next = count_cur;
      utf8_skip_next       = skip_cur;
    end else begin
      case (mode_cur)
        MODE_ESC: begin
          if (in_byte == CHAR_LOWER_X || in_byte == CHAR_LOWER_U) begin
            scan_mode_next   = MODE_HEX;
            hex_value_next   = 16'd0;
            wide_escape_next = (in_byte == CHAR_LOWER_U);
            digits_left_next = (in_byte == CHAR_LOWER_U) ? 3'd4 : 3'd2;
            err = end_of_text;
          end else if (simple[8]) begin
            scan_mode_next = MODE_TEXT;
            n  = 2'd1;
            b0 = simple[7:0];
          end else begin
            err = 1'b1;
          end
        end
        MODE_HEX: begin
          if (!digit[4]) begin
            err = 1'b1;
          end else begin
            hex_value_next = hex_acc;
            if (digits_cur > 3'd1) begin
              digits_left_next = digits_cur - 3'd1;
              err = end_of_text;
            end else begin
              digits_left_next = 3'd0;
              scan_mode_next   = MODE_TEXT;
              if (!wide_cur || hex_acc < 16'h0080) begin
                n  = 2'd1;
                b0 = hex_acc[7:0];
              end else if (hex_acc < 16'h0800) begin
                n  = 2'd2;
                b0 = 8'hC0 | {3'd0, hex_acc[10:6]};
                b1 = 8'h80 | {2'd0, hex_acc[5:0]};
              end else begin
                n  = 2'd3;
                b0 = 8'hE0 | {4'd0, hex_acc[15:12]};
                b1 = 8'h80 | {2'd0, hex_acc[11:6]};
                b2 = 8'h80 | {2'd0, hex_acc[5:0]};
              end
            end
          end
        end
        default: begin
          if (in_byte != CHAR_BACKSLASH) begin
            n  = 2'd1;
            b0 = in_byte;
          end else begin
            escape_column_next = column;
            err_col            = column;
            scan_mode_next     = MODE_ESC;
            err = end_of_text;
          end
        end
      endcase
    end

    if (err) begin
      scan_mode_next = MODE_TEXT;
      drop_rest_next = 1'b1;
    end
    if (end_of_text) begin
      scan_mode_next       = MODE_TEXT;
      hex_value_next       = 16'd0;
      digits_left_next     = 3'd0;
      wide_escape_next     = 1'b0;
      codepoint_count_next = '0;
      utf8_skip_next       = 2'd0;
      escape_column_next   = '0;
      drop_rest_next       = 1'b0;
    end

    err_wide = EW'(err_col);
    job_valid          = err || (n != 2'd0);
    job.count          = err ? 2'd1 : n;
    job.bytes          = err ? '0 : {b2, b1, b0};
    job.is_error       = err;
    job.error_column   = err ? err_wide[esd_pkg::ERROR_COLUMN_BITS-1:0] : '0;
    job.done           = err || end_of_text;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode       <= MODE_TEXT;
      hex_value       <= 16'd0;
      digits_left     <= 3'd0;
      wide_escape     <= 1'b0;
      codepoint_count <= '0;
      utf8_skip       <= 2'd0;
      escape_column   <= '0;
      base_column     <= '0;
      drop_rest       <= 1'b0;
    end else if (fire) begin
      scan_mode       <= scan_mode_next;
      hex_value       <= hex_value_next;
      digits_left     <= digits_left_next;
      wide_escape     <= wide_escape_next;
      codepoint_count <= codepoint_count_next;
      utf8_skip       <= utf8_skip_next;
      escape_column   <= escape_column_next;
      base_column     <= base_column_next;
      drop_rest       <= drop_rest_next;
    end
  end

endmodule

>>> rtl/esd_queue.sv
// short job queue between the front and back stages
module esd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  esd_pkg::job_t push_job,
  output logic          ready,
  input  logic          pop,
  output logic          head_valid,
  output esd_pkg::job_t head_job
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PW    = $clog2(DEPTH);

  esd_pkg::job_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign ready      = (count != (PW+1)'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_job;
        wr_ptr        <= wr_ptr + PW'(1);
      end
      if (pop) rd_ptr <= rd_ptr + PW'(1);
      case ({push, pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PW+1)'(DEPTH)) else $error("queue count past depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (ready || pop)) else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid) else $error("pop from empty queue");

endmodule

>>> rtl/esd_back.sv
// back stage: expands each job into its result items through the output register
module esd_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  esd_pkg::job_t q_job,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          is_error,
  output logic [15:0]   error_column,
  output logic          literal_done,
  output logic          run_last
);

  logic [1:0] idx;
  logic       last;
  logic       load;

  assign last  = (idx == q_job.count - 2'd1);
  assign load  = q_valid && (!out_valid || !out_stall);
  assign q_pop = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid    <= 1'b1;
        idx          <= last ? 2'd0 : idx + 2'd1;
        out_byte     <= q_job.bytes[idx];
        is_error     <= q_job.is_error;
        error_column <= q_job.error_column;
        literal_done <= q_job.done && last;
        run_last     <= last;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_job_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (q_job.count != 2'd0)) else $error("empty job in queue");

  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> (idx < q_job.count)) else $error("result index past job");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_byte) && $stable(is_error) &&
                                  $stable(error_column) && $stable(literal_done) &&
                                  $stable(run_last)))
    else $error("stalled result changed");

endmodule
